@@ sv/assert_macros.svh @@
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every rising clock edge outside reset
`define MDIO_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// checked on every rising clock edge, reset included
`define MDIO_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define MDIO_ASSERT(lbl, clk, rst_n, prop)
`define MDIO_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ sv/mdio22_pkg.sv @@
package mdio22_pkg;

    localparam int PREAMBLE_LENGTH = 32;
    localparam int BIT_COUNT_W     = 7;
    localparam int TOTAL_BITS      = PREAMBLE_LENGTH + 32;
    localparam int TA_INDEX        = 14;
    localparam int DATA_INDEX      = 16;

    localparam logic [BIT_COUNT_W-1:0] PREAMBLE_END = BIT_COUNT_W'(PREAMBLE_LENGTH);
    localparam logic [BIT_COUNT_W-1:0] FRAME_END    = BIT_COUNT_W'(TOTAL_BITS);
    localparam logic [BIT_COUNT_W-1:0] TA_START     = BIT_COUNT_W'(PREAMBLE_LENGTH + TA_INDEX);
    localparam logic [BIT_COUNT_W-1:0] DATA_START   = BIT_COUNT_W'(PREAMBLE_LENGTH + DATA_INDEX);

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd48;

    localparam logic [1:0] FRAME_ST  = 2'b01;
    localparam logic [1:0] OP_READ   = 2'b10;
    localparam logic [1:0] OP_WRITE  = 2'b01;
    localparam logic [1:0] FRAME_TA  = 2'b10;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_START  = 2'd1,
        MODE_STATUS = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic        is_write;
        logic [4:0]  phy_address;
        logic [4:0]  reg_address;
        logic [15:0] write_data;
        logic        mdio_in;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        idle;
        logic        start_ignored;
        logic        mdc;
        logic        mdio_out;
        logic        mdio_drive;
    } result_t;

endpackage

@@ sv/mdio22_cfg_if.sv @@
interface mdio22_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] mdc_half_period;

    modport source (output valid, output mdc_half_period, input ready);
    modport sink (input valid, input mdc_half_period, output ready);
endinterface

@@ sv/mdio22_req_if.sv @@
interface mdio22_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        is_write;
    logic [4:0]  phy_address;
    logic [4:0]  reg_address;
    logic [15:0] write_data;
    logic        mdio_in;

    modport source (output valid, output mode, output is_write, output phy_address,
                    output reg_address, output write_data, output mdio_in, input ready);
    modport sink (input valid, input mode, input is_write, input phy_address,
                  input reg_address, input write_data, input mdio_in, output ready);
endinterface

@@ sv/mdio22_rsp_if.sv @@
interface mdio22_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        idle;
    logic        start_ignored;
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;

    modport source (output valid, output read_data, output idle, output start_ignored,
                    output mdc, output mdio_out, output mdio_drive, input ready);
    modport sink (input valid, input read_data, input idle, input start_ignored,
                  input mdc, input mdio_out, input mdio_drive, output ready);
endinterface

@@ sv/mdio22_engine.sv @@
module mdio22_engine
    import mdio22_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  item_t      item,
    input  logic [7:0] half_period,
    output result_t    result
);

    logic [31:0]            frame_shift_reg, frame_shift_next;
    logic [BIT_COUNT_W-1:0] bit_count_reg, bit_count_next;
    logic [7:0]             divider_count_reg, divider_count_next;
    logic                   mdc_level_reg, mdc_level_next;
    logic                   busy_reg, busy_next;
    logic                   read_frame_reg, read_frame_next;
    logic [15:0]            captured_reg, captured_next;

    logic [7:0] half;
    logic       ignored;
    logic       shift_in;
    logic       level;
    logic       drive;

    always_comb
    begin
        frame_shift_next   = frame_shift_reg;
        bit_count_next     = bit_count_reg;
        divider_count_next = divider_count_reg;
        mdc_level_next     = mdc_level_reg;
        busy_next          = busy_reg;
        read_frame_next    = read_frame_reg;
        captured_next      = captured_reg;
        ignored            = 1'b0;
        shift_in           = 1'b0;
        half               = (half_period == 8'd0) ? 8'd1 : half_period;

        unique case (item.mode)
            MODE_TICK:
            begin
                if (busy_reg)
                begin
                    if ({1'b0, divider_count_reg} + 9'd1 >= {1'b0, half})
                    begin
                        divider_count_next = 8'd0;
                        mdc_level_next     = !mdc_level_reg;
                        if (!mdc_level_reg)
                        begin
                            // rising mdc: bit taken, next bit presented
                            if (bit_count_reg < FRAME_END)
                            begin
                                if (bit_count_reg >= PREAMBLE_END)
                                begin
                                    shift_in = read_frame_reg && (bit_count_reg >= DATA_START)
                                               && item.mdio_in;
                                    frame_shift_next = {frame_shift_reg[30:0], shift_in};
                                end
                                bit_count_next = bit_count_reg + 1'b1;
                                if (bit_count_next >= FRAME_END && read_frame_reg)
                                begin
                                    captured_next = frame_shift_next[15:0];
                                end
                            end
                        end
                        else if (bit_count_reg >= FRAME_END)
                        begin
                            busy_next = 1'b0;
                        end
                    end
                    else
                    begin
                        divider_count_next = divider_count_reg + 8'd1;
                    end
                end
            end
            MODE_START:
            begin
                if (busy_reg)
                begin
                    ignored = 1'b1;
                end
                else
                begin
                    frame_shift_next = {FRAME_ST, item.is_write ? OP_WRITE : OP_READ,
                                        item.phy_address, item.reg_address, FRAME_TA,
                                        item.is_write ? item.write_data : 16'h0000};
                    read_frame_next    = !item.is_write;
                    bit_count_next     = '0;
                    divider_count_next = 8'd0;
                    mdc_level_next     = 1'b0;
                    busy_next          = 1'b1;
                end
            end
            default:
            begin
                // status read, no action
            end
        endcase

        level = 1'b0;
        drive = 1'b0;
        if (busy_next && bit_count_next < FRAME_END)
        begin
            if (bit_count_next < PREAMBLE_END)
            begin
                level = 1'b1;
                drive = 1'b1;
            end
            else if (!(read_frame_next && bit_count_next >= TA_START))
            begin
                level = frame_shift_next[31];
                drive = 1'b1;
            end
        end

        result.read_data     = captured_next;
        result.idle          = !busy_next;
        result.start_ignored = ignored;
        result.mdc           = mdc_level_next;
        result.mdio_out      = level;
        result.mdio_drive    = drive;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_shift_reg   <= '0;
            bit_count_reg     <= '0;
            divider_count_reg <= '0;
            mdc_level_reg     <= 1'b0;
            busy_reg          <= 1'b0;
            read_frame_reg    <= 1'b0;
            captured_reg      <= '0;
        end
        else if (accept)
        begin
            frame_shift_reg   <= frame_shift_next;
            bit_count_reg     <= bit_count_next;
            divider_count_reg <= divider_count_next;
            mdc_level_reg     <= mdc_level_next;
            busy_reg          <= busy_next;
            read_frame_reg    <= read_frame_next;
            captured_reg      <= captured_next;
        end
    end

endmodule

@@ sv/mdio_clause22_master_top.sv @@
// Clause 22 MDIO management master.
// req carries one item per transaction: a tick of the divider, a frame start
// (opcode, phy and register address, write data) or a status read; mdio_in is
// the pin level sampled with that item.
// rsp returns exactly one result per item: captured read data, idle, a flag
// for a start that found a frame running, and the mdc, mdio_out and
// mdio_drive pin levels after the item.
// cfg writes mdc_half_period (ticks per mdc half period, zero acts as one);
// a write takes effect at once, mid-frame too. cfg is always ready.
// The result of an item accepted at one clock edge is registered and valid
// after it. One item per cycle is sustained while rsp takes results; the frame
// state update is a single pass of logic between the state registers and the
// result register. A frame is 64 bits, 32 preamble and 32 frame bits; each mdc
// period takes 2 * mdc_half_period tick items. When rsp stalls the result is
// held and req takes one more item only once the held result is taken.
// Reset clears the frame state and captured data, sets the half period to 48
// and empties the result register.
module mdio_clause22_master_top
    import mdio22_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    mdio22_cfg_if.sink    cfg,
    mdio22_req_if.sink    req,
    mdio22_rsp_if.source  rsp
);

`include "assert_macros.svh"

    logic [7:0] half_period_reg;
    logic       rsp_valid_reg;
    result_t    rsp_data_reg;
    result_t    result_next;
    item_t      item;
    logic       accept;

    assign cfg.ready = 1'b1;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign item.mode        = mode_t'(req.mode);
    assign item.is_write    = req.is_write;
    assign item.phy_address = req.phy_address;
    assign item.reg_address = req.reg_address;
    assign item.write_data  = req.write_data;
    assign item.mdio_in     = req.mdio_in;

    mdio22_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .half_period (half_period_reg),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                half_period_reg <= cfg.mdc_half_period;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg <= result_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_data     = rsp_data_reg.read_data;
    assign rsp.idle          = rsp_data_reg.idle;
    assign rsp.start_ignored = rsp_data_reg.start_ignored;
    assign rsp.mdc           = rsp_data_reg.mdc;
    assign rsp.mdio_out      = rsp_data_reg.mdio_out;
    assign rsp.mdio_drive    = rsp_data_reg.mdio_drive;

    `MDIO_ASSERT(a_accept_gives_result, clk, rst_n, accept |=> rsp_valid_reg)
    `MDIO_ASSERT(a_out_needs_drive, clk, rst_n, rsp_valid_reg |-> (!rsp_data_reg.mdio_out || rsp_data_reg.mdio_drive))
    `MDIO_ASSERT(a_ignored_when_busy, clk, rst_n, rsp_valid_reg && rsp_data_reg.start_ignored |-> !rsp_data_reg.idle)
    `MDIO_ASSERT(a_idle_mdc_low, clk, rst_n, rsp_valid_reg && rsp_data_reg.idle |-> !rsp_data_reg.mdc)
    `MDIO_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !rsp_valid_reg)

endmodule
